FILE: hdl/ugns_pkg.sv
// ----------------------------------------------------------------------------
// ugns_pkg
// Shared types and constants of the uniform grid neighbor search block.
// ----------------------------------------------------------------------------
package ugns_pkg;

  localparam int POS_W      = 16;
  localparam int PROD_W     = 35;
  localparam int FRAC_SHIFT = 20;
  localparam int RAW_W      = PROD_W - FRAC_SHIFT;
  localparam int IDX_W      = 10;
  localparam int ID_W       = 10;
  localparam int KIND_W     = 2;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_BUILD = 2'd1,
    KIND_QUERY = 2'd2,
    KIND_NEXT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    REG_PCOUNT  = 3'd0,
    REG_CELLS_X = 3'd1,
    REG_CELLS_Y = 3'd2,
    REG_CELLS_Z = 3'd3,
    REG_INV_SP  = 3'd4,
    REG_OFFSET  = 3'd5
  } reg_e;

  localparam logic [10:0] PCOUNT_RST = 11'd1024;
  localparam logic [4:0]  CELLS_RST  = 5'd16;
  localparam logic [15:0] INV_SP_RST = 16'd4096;
  localparam logic [15:0] OFFSET_RST = 16'd1024;

  typedef struct packed {
    logic [10:0] particle_count;
    logic [4:0]  cells_x;
    logic [4:0]  cells_y;
    logic [4:0]  cells_z;
    logic [15:0] inv_spacing;
    logic [15:0] grid_offset;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_PREP0,
    ST_PREP1,
    ST_CLR,
    ST_BRD,
    ST_BMUL,
    ST_BCLAMP,
    ST_BXY,
    ST_BCN,
    ST_CRD,
    ST_CWR,
    ST_PRD,
    ST_PWR,
    ST_PLAST,
    ST_FRD,
    ST_FWR,
    ST_QRD,
    ST_QMUL,
    ST_QWIN,
    ST_LXY,
    ST_LCN,
    ST_LRS,
    ST_LRE,
    ST_LEND,
    ST_NCHK,
    ST_NRD,
    ST_NCMP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic accept;
    logic i_clr;
    logic i_inc;
    logic run_clr;
    logic build_start;
    logic clr_cnt;
    logic pos_rd;
    logic pos_from_q;
    logic mul;
    logic clamp;
    logic win_set;
    logic xy;
    logic cn;
    logic cur_sel;
    logic cnt_rd_cell;
    logic cnt_rd_idx;
    logic cnt_inc;
    logic pre_wr;
    logic pre_last;
    logic start_rd_cell;
    logic start_rd_next;
    logic start_dec;
    logic pos_take;
    logic end_take;
    logic deact;
    logic advance;
    logic id_rd;
    logic out_load;
    logic out_found;
  } cmd_t;

  typedef struct packed {
    logic i_eq_n;
    logic i_eq_nc;
    logic win_ok;
    logic active;
    logic pos_lt_end;
    logic cur_last;
    logic id_ne;
    logic out_free;
  } status_t;

endpackage

FILE: hdl/uniform_grid_neighbor_search.sv
// ----------------------------------------------------------------------------
// uniform_grid_neighbor_search
// Uniform grid binning of 3D points with a windowed neighbor query.
// ----------------------------------------------------------------------------
// usage:
//   input stream items carry a kind in tuser: load stores one position,
//   build bins all particles by counting sort, query opens the 3x3x3 cell
//   window around a particle, next returns one neighbor id per item
//   only next produces an output item: id in tdata, found flag in tuser
//   one item is worked at a time; tready is high only when the sequencer
//   is idle, and a finished result waits in the output register while the
//   sequencer goes idle and takes the next item
//   a stalled receiver holds the sequencer before it overwrites a result
//   reset empties the query window, clears the output register and marks
//   the grid unbuilt; no clearing pass is needed
//   the user writes registers on the apb port, which the block does not guard, only while the block is idle
// ----------------------------------------------------------------------------
module uniform_grid_neighbor_search #(
  parameter int MAX_PARTICLES  = 1024,
  parameter int MAX_AXIS_CELLS = 16,
  parameter int MAX_CELLS      = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // particle_index, pos_x, pos_y, pos_z
  input  logic [1:0]  s_axis_tuser,   // kind
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // neighbour_id
  output logic [0:0]  m_axis_tuser    // found
);

  localparam int PW = ugns_pkg::POS_W;

  ugns_pkg::cfg_t    cfg_q;
  ugns_pkg::cmd_t    cmd;
  ugns_pkg::status_t sts;
  ugns_pkg::reg_e    reg_sel;
  ugns_pkg::kind_e   in_kind;
  logic [ugns_pkg::ID_W-1:0] out_id;
  logic out_found;

  assign reg_sel = ugns_pkg::reg_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.particle_count <= ugns_pkg::PCOUNT_RST;
      cfg_q.cells_x        <= ugns_pkg::CELLS_RST;
      cfg_q.cells_y        <= ugns_pkg::CELLS_RST;
      cfg_q.cells_z        <= ugns_pkg::CELLS_RST;
      cfg_q.inv_spacing    <= ugns_pkg::INV_SP_RST;
      cfg_q.grid_offset    <= ugns_pkg::OFFSET_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        ugns_pkg::REG_PCOUNT:  cfg_q.particle_count <= pwdata[10:0];
        ugns_pkg::REG_CELLS_X: cfg_q.cells_x        <= pwdata[4:0];
        ugns_pkg::REG_CELLS_Y: cfg_q.cells_y        <= pwdata[4:0];
        ugns_pkg::REG_CELLS_Z: cfg_q.cells_z        <= pwdata[4:0];
        ugns_pkg::REG_INV_SP:  cfg_q.inv_spacing    <= pwdata[15:0];
        ugns_pkg::REG_OFFSET:  cfg_q.grid_offset    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      ugns_pkg::REG_PCOUNT:  prdata = 32'(cfg_q.particle_count);
      ugns_pkg::REG_CELLS_X: prdata = 32'(cfg_q.cells_x);
      ugns_pkg::REG_CELLS_Y: prdata = 32'(cfg_q.cells_y);
      ugns_pkg::REG_CELLS_Z: prdata = 32'(cfg_q.cells_z);
      ugns_pkg::REG_INV_SP:  prdata = 32'(cfg_q.inv_spacing);
      ugns_pkg::REG_OFFSET:  prdata = 32'(cfg_q.grid_offset);
      default:               prdata = '0;
    endcase
  end

  assign in_kind = ugns_pkg::kind_e'(s_axis_tuser);

  ugns_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_kind_i  (in_kind),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ugns_dp #(
    .MAX_PARTICLES  (MAX_PARTICLES),
    .MAX_AXIS_CELLS (MAX_AXIS_CELLS),
    .MAX_CELLS      (MAX_CELLS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_kind_i   (in_kind),
    .in_index_i  (s_axis_tdata[ugns_pkg::IDX_W-1:0]),
    .in_pos_i    (s_axis_tdata[ugns_pkg::IDX_W +: 3*PW]),
    .out_id_o    (out_id),
    .out_found_o (out_found),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = 16'(out_id);
  assign m_axis_tuser = out_found;

endmodule

FILE: hdl/ugns_dp.sv
// ----------------------------------------------------------------------------
// ugns_dp
// Datapath: position, count, start and id memories, binning arithmetic,
// query window and cursor, and the result register.
// ----------------------------------------------------------------------------
module ugns_dp #(
  parameter int MAX_PARTICLES  = 1024,
  parameter int MAX_AXIS_CELLS = 16,
  parameter int MAX_CELLS      = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ugns_pkg::cfg_t                cfg_i,
  input  ugns_pkg::cmd_t                cmd_i,
  output ugns_pkg::status_t             sts_o,
  input  ugns_pkg::kind_e               in_kind_i,
  input  logic [ugns_pkg::IDX_W-1:0]    in_index_i,
  input  logic [3*ugns_pkg::POS_W-1:0]  in_pos_i,
  output logic [ugns_pkg::ID_W-1:0]     out_id_o,
  output logic                          out_found_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i
);

  localparam int PIW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
  localparam int PCW = $clog2(MAX_PARTICLES + 1);
  localparam int CW  = (MAX_AXIS_CELLS > 1) ? $clog2(MAX_AXIS_CELLS) : 1;
  localparam int CW1 = $clog2(MAX_AXIS_CELLS + 1);
  localparam int XYW = 2 * CW1;
  localparam int FW  = 3 * CW1;
  localparam int CAW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int SAW = $clog2(MAX_CELLS + 1);
  localparam int IW  = (PCW > SAW) ? PCW : SAW;
  localparam int PW  = ugns_pkg::POS_W;
  localparam int RW  = ugns_pkg::RAW_W;
  localparam int PROD_W_L = ugns_pkg::PROD_W;

  function automatic logic [CW1-1:0] axis_size(logic [4:0] v);
    logic [CW1-1:0] r;
    if (v == 5'd0) begin
      r = CW1'(1);
    end else if (32'(v) > 32'(MAX_AXIS_CELLS)) begin
      r = CW1'(MAX_AXIS_CELLS);
    end else begin
      r = CW1'(v);
    end
    return r;
  endfunction

  function automatic logic [PIW-1:0] idx_mod(logic [ugns_pkg::IDX_W-1:0] v);
    logic [31:0] r;
    r = 32'(v);
    for (int k = ugns_pkg::IDX_W - 1; k >= 0; k--) begin
      if (r >= (32'(MAX_PARTICLES) << k)) begin
        r = r - (32'(MAX_PARTICLES) << k);
      end
    end
    return PIW'(r);
  endfunction

  // configuration derived values
  logic [CW1-1:0] nax [3];
  logic [PCW-1:0] npart;
  logic [XYW-1:0] nxny_q;
  logic [FW-1:0]  nc_full;
  logic [SAW-1:0] nc_q;

  assign nax[0] = axis_size(cfg_i.cells_x);
  assign nax[1] = axis_size(cfg_i.cells_y);
  assign nax[2] = axis_size(cfg_i.cells_z);
  assign npart  = (32'(cfg_i.particle_count) > 32'(MAX_PARTICLES)) ?
                  PCW'(MAX_PARTICLES) : PCW'(cfg_i.particle_count);
  assign nc_full = FW'(nxny_q) * FW'(nax[2]);

  always_ff @(posedge clk_i) begin
    nxny_q <= XYW'(nax[0]) * XYW'(nax[1]);
    nc_q   <= (32'(nc_full) > 32'(MAX_CELLS)) ? SAW'(MAX_CELLS) : SAW'(nc_full);
  end

  // memories
  logic [3*PW-1:0] pos_mem   [MAX_PARTICLES];
  logic [PCW-1:0]  cnt_mem   [MAX_CELLS];
  logic [PCW-1:0]  start_mem [MAX_CELLS+1];
  logic [PIW-1:0]  ids_mem   [MAX_PARTICLES];

  // control registers
  logic [IW-1:0]  i_q;
  logic [PCW-1:0] run_q;
  logic           built_q;
  logic [SAW-1:0] hw_q;
  logic [PIW-1:0] qpart_q;
  logic           active_q;
  logic [PCW-1:0] cur_pos_q;
  logic [PCW-1:0] cur_end_q;

  // payload registers
  logic [3*PW-1:0]            pos_rd_q;
  logic signed [PROD_W_L-1:0] prod_q [3];
  logic [CW-1:0]              coord_q [3];
  logic [CW-1:0]              lo_q [3];
  logic [CW-1:0]              hi_q [3];
  logic [CW-1:0]              cur_q [3];
  logic [XYW-1:0]             xy_q;
  logic [SAW-1:0]             cell_q;
  logic [PCW-1:0]             cnt_rd_q;
  logic [PCW-1:0]             st_rd_q;
  logic [PIW-1:0]             id_rd_q;
  logic [ugns_pkg::ID_W-1:0]  out_id_q;
  logic                       out_found_q;
  logic                       out_valid_q;

  // position memory
  logic [PIW-1:0] pos_addr;
  logic [PIW-1:0] in_idx;

  assign in_idx   = idx_mod(in_index_i);
  assign pos_addr = cmd_i.pos_from_q ? qpart_q : i_q[PIW-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && (in_kind_i == ugns_pkg::KIND_LOAD)) begin
      pos_mem[in_idx] <= in_pos_i;
    end
    if (cmd_i.pos_rd) begin
      pos_rd_q <= pos_mem[pos_addr];
    end
  end

  // binning arithmetic
  logic signed [PROD_W_L-1:0] prod_d [3];
  logic signed [RW-1:0]       raw [3];
  logic signed [15:0]         c16 [3];
  logic signed [15:0]         nm1 [3];
  logic signed [15:0]         lo16 [3];
  logic signed [15:0]         hi16 [3];
  logic [CW-1:0]              clamp_d [3];
  logic                       win_ok;

  always_comb begin
    win_ok = 1'b1;
    for (int a = 0; a < 3; a++) begin
      logic signed [PW-1:0] p;
      logic signed [17:0]   s;
      p = $signed(pos_rd_q[a*PW +: PW]);
      s = 18'(p) + 18'($signed({1'b0, cfg_i.grid_offset}));
      prod_d[a] = PROD_W_L'(s) * PROD_W_L'($signed({1'b0, cfg_i.inv_spacing}));
      raw[a] = prod_q[a][PROD_W_L-1:ugns_pkg::FRAC_SHIFT];
      c16[a] = 16'(raw[a]);
      nm1[a] = $signed(16'(nax[a])) - 16'sd1;
      if (c16[a] < 16'sd0) begin
        clamp_d[a] = '0;
      end else if (c16[a] > nm1[a]) begin
        clamp_d[a] = CW'(nm1[a]);
      end else begin
        clamp_d[a] = CW'(c16[a]);
      end
      lo16[a] = (c16[a] - 16'sd1 < 16'sd0) ? 16'sd0 : c16[a] - 16'sd1;
      hi16[a] = (c16[a] + 16'sd1 > nm1[a]) ? nm1[a] : c16[a] + 16'sd1;
      if (lo16[a] > hi16[a]) begin
        win_ok = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      if (cmd_i.mul) begin
        prod_q[a] <= prod_d[a];
      end
      if (cmd_i.clamp) begin
        coord_q[a] <= clamp_d[a];
      end
    end
  end

  // cell number
  logic [CW-1:0] sx, sy, sz;
  logic [FW-1:0] cn_full;

  assign sx      = cmd_i.cur_sel ? cur_q[0] : coord_q[0];
  assign sy      = cmd_i.cur_sel ? cur_q[1] : coord_q[1];
  assign sz      = cmd_i.cur_sel ? cur_q[2] : coord_q[2];
  assign cn_full = FW'(xy_q) * FW'(nax[2]) + FW'(sz);

  always_ff @(posedge clk_i) begin
    if (cmd_i.xy) begin
      xy_q <= XYW'(sx) * XYW'(nax[1]) + XYW'(sy);
    end
    if (cmd_i.cn) begin
      cell_q <= (32'(cn_full) >= 32'(nc_q)) ? SAW'(nc_q - SAW'(1)) : SAW'(cn_full);
    end
  end

  // count memory
  logic           cnt_we;
  logic [CAW-1:0] cnt_wa;
  logic [PCW-1:0] cnt_wd;

  always_comb begin
    cnt_we = cmd_i.clr_cnt | cmd_i.cnt_inc;
    cnt_wa = cmd_i.clr_cnt ? i_q[CAW-1:0] : cell_q[CAW-1:0];
    cnt_wd = cmd_i.clr_cnt ? '0 : PCW'(cnt_rd_q + PCW'(1));
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    if (cmd_i.cnt_rd_cell) begin
      cnt_rd_q <= cnt_mem[cell_q[CAW-1:0]];
    end else if (cmd_i.cnt_rd_idx) begin
      cnt_rd_q <= cnt_mem[i_q[CAW-1:0]];
    end
  end

  // start memory and sorted ids
  logic           st_we;
  logic [SAW-1:0] st_wa;
  logic [PCW-1:0] st_wd;
  logic [SAW-1:0] st_ra;
  logic [PCW-1:0] st_dec;

  assign st_dec = PCW'(st_rd_q - PCW'(1));

  always_comb begin
    st_we = cmd_i.pre_wr | cmd_i.pre_last | cmd_i.start_dec;
    st_wa = cmd_i.start_dec ? cell_q : i_q[SAW-1:0];
    if (cmd_i.start_dec) begin
      st_wd = st_dec;
    end else if (cmd_i.pre_wr) begin
      st_wd = PCW'(run_q + cnt_rd_q);
    end else begin
      st_wd = run_q;
    end
    st_ra = cmd_i.start_rd_next ? SAW'(cell_q + SAW'(1)) : cell_q;
  end

  always_ff @(posedge clk_i) begin
    if (st_we) begin
      start_mem[st_wa] <= st_wd;
    end
    if (cmd_i.start_rd_cell || cmd_i.start_rd_next) begin
      st_rd_q <= (built_q && (st_ra <= hw_q)) ? start_mem[st_ra] : '0;
    end
    if (cmd_i.start_dec) begin
      ids_mem[st_dec[PIW-1:0]] <= i_q[PIW-1:0];
    end
    if (cmd_i.id_rd) begin
      id_rd_q <= ids_mem[cur_pos_q[PIW-1:0]];
    end
  end

  // counters, window and cursor
  logic cur_last;

  assign cur_last = (cur_q[0] == hi_q[0]) && (cur_q[1] == hi_q[1]) &&
                    (cur_q[2] == hi_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q       <= '0;
      run_q     <= '0;
      built_q   <= 1'b0;
      hw_q      <= '0;
      qpart_q   <= '0;
      active_q  <= 1'b0;
      cur_pos_q <= '0;
      cur_end_q <= '0;
    end else begin
      if (cmd_i.i_clr) begin
        i_q <= '0;
      end else if (cmd_i.i_inc) begin
        i_q <= IW'(i_q + IW'(1));
      end
      if (cmd_i.run_clr) begin
        run_q <= '0;
      end else if (cmd_i.pre_wr) begin
        run_q <= PCW'(run_q + cnt_rd_q);
      end
      if (cmd_i.accept && (in_kind_i == ugns_pkg::KIND_QUERY)) begin
        qpart_q <= in_idx;
      end
      if (cmd_i.build_start) begin
        built_q  <= 1'b1;
        active_q <= 1'b0;
        if (nc_q > hw_q) begin
          hw_q <= nc_q;
        end
      end else if (cmd_i.win_set) begin
        active_q <= win_ok;
      end else if (cmd_i.deact) begin
        active_q <= 1'b0;
      end
      if (cmd_i.pos_take) begin
        cur_pos_q <= st_rd_q;
      end else if (cmd_i.id_rd) begin
        cur_pos_q <= PCW'(cur_pos_q + PCW'(1));
      end
      if (cmd_i.end_take) begin
        cur_end_q <= st_rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.win_set) begin
      for (int a = 0; a < 3; a++) begin
        lo_q[a]  <= CW'(lo16[a]);
        hi_q[a]  <= CW'(hi16[a]);
        cur_q[a] <= CW'(lo16[a]);
      end
    end else if (cmd_i.advance) begin
      if (cur_q[2] == hi_q[2]) begin
        cur_q[2] <= lo_q[2];
        if (cur_q[1] == hi_q[1]) begin
          cur_q[1] <= lo_q[1];
          cur_q[0] <= CW'(cur_q[0] + CW'(1));
        end else begin
          cur_q[1] <= CW'(cur_q[1] + CW'(1));
        end
      end else begin
        cur_q[2] <= CW'(cur_q[2] + CW'(1));
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_found_q <= cmd_i.out_found;
      out_id_q    <= cmd_i.out_found ? ugns_pkg::ID_W'(id_rd_q) : '0;
    end
  end

  assign out_id_o    = out_id_q;
  assign out_found_o = out_found_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    sts_o            = '0;
    sts_o.i_eq_n     = (i_q == IW'(npart));
    sts_o.i_eq_nc    = (i_q == IW'(nc_q));
    sts_o.win_ok     = win_ok;
    sts_o.active     = active_q;
    sts_o.pos_lt_end = (cur_pos_q < cur_end_q);
    sts_o.cur_last   = cur_last;
    sts_o.id_ne      = (id_rd_q != qpart_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule

FILE: hdl/ugns_ctrl.sv
// ----------------------------------------------------------------------------
// ugns_ctrl
// Controller: sequences load, build, query and next items over the datapath.
// ----------------------------------------------------------------------------
module ugns_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  ugns_pkg::kind_e   in_kind_i,
  output logic              in_ready_o,
  input  ugns_pkg::status_t sts_i,
  output ugns_pkg::cmd_t    cmd_o
);

  ugns_pkg::state_e state_q, state_d;
  logic fill_q, fill_d;
  logic nxt_q, nxt_d;
  logic fnd_q, fnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ugns_pkg::ST_IDLE;
      fill_q  <= 1'b0;
      nxt_q   <= 1'b0;
      fnd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      nxt_q   <= nxt_d;
      fnd_q   <= fnd_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    nxt_d      = nxt_q;
    fnd_d      = fnd_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ugns_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept  = 1'b1;
          cmd_o.i_clr   = 1'b1;
          cmd_o.run_clr = 1'b1;
          nxt_d         = (in_kind_i == ugns_pkg::KIND_NEXT);
          case (in_kind_i)
            ugns_pkg::KIND_BUILD: state_d = ugns_pkg::ST_PREP0;
            ugns_pkg::KIND_QUERY: state_d = ugns_pkg::ST_QRD;
            ugns_pkg::KIND_NEXT:  state_d = ugns_pkg::ST_NCHK;
            default:              state_d = ugns_pkg::ST_IDLE;
          endcase
        end
      end
      ugns_pkg::ST_PREP0: state_d = ugns_pkg::ST_PREP1;
      ugns_pkg::ST_PREP1: begin
        cmd_o.build_start = 1'b1;
        state_d           = ugns_pkg::ST_CLR;
      end
      ugns_pkg::ST_CLR: begin
        if (sts_i.i_eq_nc) begin
          cmd_o.i_clr = 1'b1;
          fill_d      = 1'b0;
          state_d     = ugns_pkg::ST_BRD;
        end else begin
          cmd_o.clr_cnt = 1'b1;
          cmd_o.i_inc   = 1'b1;
        end
      end
      ugns_pkg::ST_BRD: begin
        if (sts_i.i_eq_n) begin
          if (fill_q) begin
            state_d = ugns_pkg::ST_IDLE;
          end else begin
            cmd_o.i_clr = 1'b1;
            state_d     = ugns_pkg::ST_PRD;
          end
        end else begin
          cmd_o.pos_rd = 1'b1;
          state_d      = ugns_pkg::ST_BMUL;
        end
      end
      ugns_pkg::ST_BMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ugns_pkg::ST_BCLAMP;
      end
      ugns_pkg::ST_BCLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = ugns_pkg::ST_BXY;
      end
      ugns_pkg::ST_BXY: begin
        cmd_o.xy = 1'b1;
        state_d  = ugns_pkg::ST_BCN;
      end
      ugns_pkg::ST_BCN: begin
        cmd_o.cn = 1'b1;
        state_d  = fill_q ? ugns_pkg::ST_FRD : ugns_pkg::ST_CRD;
      end
      ugns_pkg::ST_CRD: begin
        cmd_o.cnt_rd_cell = 1'b1;
        state_d           = ugns_pkg::ST_CWR;
      end
      ugns_pkg::ST_CWR: begin
        cmd_o.cnt_inc = 1'b1;
        cmd_o.i_inc   = 1'b1;
        state_d       = ugns_pkg::ST_BRD;
      end
      ugns_pkg::ST_PRD: begin
        if (sts_i.i_eq_nc) begin
          state_d = ugns_pkg::ST_PLAST;
        end else begin
          cmd_o.cnt_rd_idx = 1'b1;
          state_d          = ugns_pkg::ST_PWR;
        end
      end
      ugns_pkg::ST_PWR: begin
        cmd_o.pre_wr = 1'b1;
        cmd_o.i_inc  = 1'b1;
        state_d      = ugns_pkg::ST_PRD;
      end
      ugns_pkg::ST_PLAST: begin
        cmd_o.pre_last = 1'b1;
        cmd_o.i_clr    = 1'b1;
        fill_d         = 1'b1;
        state_d        = ugns_pkg::ST_BRD;
      end
      ugns_pkg::ST_FRD: begin
        cmd_o.start_rd_cell = 1'b1;
        state_d             = ugns_pkg::ST_FWR;
      end
      ugns_pkg::ST_FWR: begin
        cmd_o.start_dec = 1'b1;
        cmd_o.i_inc     = 1'b1;
        state_d         = ugns_pkg::ST_BRD;
      end
      ugns_pkg::ST_QRD: begin
        cmd_o.pos_rd     = 1'b1;
        cmd_o.pos_from_q = 1'b1;
        state_d          = ugns_pkg::ST_QMUL;
      end
      ugns_pkg::ST_QMUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ugns_pkg::ST_QWIN;
      end
      ugns_pkg::ST_QWIN: begin
        cmd_o.win_set = 1'b1;
        state_d       = sts_i.win_ok ? ugns_pkg::ST_LXY : ugns_pkg::ST_IDLE;
      end
      ugns_pkg::ST_LXY: begin
        cmd_o.xy      = 1'b1;
        cmd_o.cur_sel = 1'b1;
        state_d       = ugns_pkg::ST_LCN;
      end
      ugns_pkg::ST_LCN: begin
        cmd_o.cn      = 1'b1;
        cmd_o.cur_sel = 1'b1;
        state_d       = ugns_pkg::ST_LRS;
      end
      ugns_pkg::ST_LRS: begin
        cmd_o.start_rd_cell = 1'b1;
        state_d             = ugns_pkg::ST_LRE;
      end
      ugns_pkg::ST_LRE: begin
        cmd_o.start_rd_next = 1'b1;
        cmd_o.pos_take      = 1'b1;
        state_d             = ugns_pkg::ST_LEND;
      end
      ugns_pkg::ST_LEND: begin
        cmd_o.end_take = 1'b1;
        state_d        = nxt_q ? ugns_pkg::ST_NCHK : ugns_pkg::ST_IDLE;
      end
      ugns_pkg::ST_NCHK: begin
        if (!sts_i.active) begin
          fnd_d   = 1'b0;
          state_d = ugns_pkg::ST_OUT;
        end else if (sts_i.pos_lt_end) begin
          state_d = ugns_pkg::ST_NRD;
        end else if (sts_i.cur_last) begin
          cmd_o.deact = 1'b1;
          fnd_d       = 1'b0;
          state_d     = ugns_pkg::ST_OUT;
        end else begin
          cmd_o.advance = 1'b1;
          state_d       = ugns_pkg::ST_LXY;
        end
      end
      ugns_pkg::ST_NRD: begin
        cmd_o.id_rd = 1'b1;
        state_d     = ugns_pkg::ST_NCMP;
      end
      ugns_pkg::ST_NCMP: begin
        if (sts_i.id_ne) begin
          fnd_d   = 1'b1;
          state_d = ugns_pkg::ST_OUT;
        end else begin
          state_d = ugns_pkg::ST_NCHK;
        end
      end
      ugns_pkg::ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_found = fnd_q;
          state_d         = ugns_pkg::ST_IDLE;
        end
      end
      default: state_d = ugns_pkg::ST_IDLE;
    endcase
  end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for uniform_grid_neighbor_search.
// The testbench loads particle positions, builds grids of many shapes and
// opens neighbor queries. Each next item is checked against an in-bench
// model of the binning and window walk. Both streams idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NPART  = 1024;
  localparam int NCELL  = 4096;
  localparam int FULL_N = 600;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_valid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_data = '0;    // particle_index, pos_x, pos_y, pos_z
  logic [1:0]  s_user = '0;    // kind
  logic        m_axis_tvalid;
  logic        m_ready = 1'b0;
  logic [15:0] m_axis_tdata;   // neighbour_id
  logic [0:0]  m_axis_tuser;   // found

  uniform_grid_neighbor_search dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .s_axis_tvalid(s_valid), .s_axis_tready, .s_axis_tdata(s_data),
    .s_axis_tuser(s_user), .m_axis_tvalid, .m_axis_tready(m_ready),
    .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  typedef struct packed {
    logic [9:0] id;
    logic       found;
  } nbr_t;

  nbr_t nbr_q[$];
  int   errors = 0;
  int   burst_left = 0;

  // grid model state
  int unsigned r_pcount, r_cx, r_cy, r_cz, r_inv, r_off;
  shortint     pos_tab[NPART][3];
  int unsigned cnt_tab[NCELL];
  int unsigned start_tab[NCELL + 1];
  int unsigned id_tab[NPART];
  int unsigned q_part, walk_pos, walk_end;
  int          win_lo[3], win_hi[3], walk[3];
  bit          walk_on;

  function automatic int unsigned axis_n(int unsigned v);
    if (v < 1) return 1;
    if (v > 16) return 16;
    return v;
  endfunction

  function automatic int unsigned grid_cells();
    int unsigned t;
    t = axis_n(r_cx) * axis_n(r_cy) * axis_n(r_cz);
    return t > NCELL ? NCELL : t;
  endfunction

  function automatic int coord_cell(shortint p);
    longint s, v;
    s = longint'(p) + longint'(r_off);
    v = s * longint'(r_inv);
    return int'(v >>> 20);
  endfunction

  function automatic int unsigned cell_index(int x, int y, int z);
    int unsigned ny, nz, nc, c;
    ny = axis_n(r_cy);
    nz = axis_n(r_cz);
    nc = grid_cells();
    c = x * ny * nz + y * nz + z;
    return c >= nc ? nc - 1 : c;
  endfunction

  function automatic int clamp_cell(int c, int unsigned n);
    if (c < 0) return 0;
    if (c > int'(n) - 1) return int'(n) - 1;
    return c;
  endfunction

  function automatic int unsigned home_cell(int unsigned i);
    return cell_index(clamp_cell(coord_cell(pos_tab[i][0]), axis_n(r_cx)),
                      clamp_cell(coord_cell(pos_tab[i][1]), axis_n(r_cy)),
                      clamp_cell(coord_cell(pos_tab[i][2]), axis_n(r_cz)));
  endfunction

  function automatic void open_walk_cell();
    int unsigned c;
    c = cell_index(walk[0], walk[1], walk[2]);
    walk_pos = start_tab[c];
    walk_end = start_tab[c + 1];
  endfunction

  function automatic void grid_build();
    int unsigned n, nc, run, c;
    n = r_pcount > NPART ? NPART : r_pcount;
    nc = grid_cells();
    run = 0;
    foreach (cnt_tab[i]) cnt_tab[i] = 0;
    for (int unsigned i = 0; i < n; i++) cnt_tab[home_cell(i)]++;
    for (int unsigned i = 0; i < nc; i++) begin
      run += cnt_tab[i];
      start_tab[i] = run;
    end
    start_tab[nc] = run;
    for (int unsigned i = 0; i < n; i++) begin
      c = home_cell(i);
      start_tab[c]--;
      id_tab[start_tab[c] % NPART] = i;
    end
    walk_on = 1'b0;
  endfunction

  function automatic void query_open(int unsigned q);
    int unsigned n[3];
    int c;
    n[0] = axis_n(r_cx);
    n[1] = axis_n(r_cy);
    n[2] = axis_n(r_cz);
    q_part = q;
    walk_on = 1'b1;
    for (int a = 0; a < 3; a++) begin
      c = coord_cell(pos_tab[q][a]);
      win_lo[a] = c - 1 < 0 ? 0 : c - 1;
      win_hi[a] = c + 1 > int'(n[a]) - 1 ? int'(n[a]) - 1 : c + 1;
      if (win_lo[a] > win_hi[a]) walk_on = 1'b0;
      walk[a] = win_lo[a];
    end
    if (walk_on) open_walk_cell();
  endfunction

  function automatic nbr_t next_neighbor();
    nbr_t r;
    int unsigned v;
    r = '0;
    while (walk_on) begin
      while (walk_pos < walk_end && walk_pos < NPART) begin
        v = id_tab[walk_pos];
        walk_pos++;
        if (v != q_part) begin
          r.id = v[9:0];
          r.found = 1'b1;
          return r;
        end
      end
      walk[2]++;
      if (walk[2] > win_hi[2]) begin
        walk[2] = win_lo[2];
        walk[1]++;
        if (walk[1] > win_hi[1]) begin
          walk[1] = win_lo[1];
          walk[0]++;
          if (walk[0] > win_hi[0]) begin
            walk_on = 1'b0;
            break;
          end
        end
      end
      open_walk_cell();
    end
    return r;
  endfunction

  task automatic write_reg(ugns_pkg::reg_e r, int unsigned v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(r) << 2;
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (r)
      ugns_pkg::REG_PCOUNT:  r_pcount = v & 32'h7ff;
      ugns_pkg::REG_CELLS_X: r_cx = v & 32'h1f;
      ugns_pkg::REG_CELLS_Y: r_cy = v & 32'h1f;
      ugns_pkg::REG_CELLS_Z: r_cz = v & 32'h1f;
      ugns_pkg::REG_INV_SP:  r_inv = v & 32'hffff;
      ugns_pkg::REG_OFFSET:  r_off = v & 32'hffff;
      default: ;
    endcase
  endtask

  task automatic set_grid(int unsigned pc, int unsigned cx, int unsigned cy,
                          int unsigned cz, int unsigned inv, int unsigned off);
    write_reg(ugns_pkg::REG_PCOUNT, pc);
    write_reg(ugns_pkg::REG_CELLS_X, cx);
    write_reg(ugns_pkg::REG_CELLS_Y, cy);
    write_reg(ugns_pkg::REG_CELLS_Z, cz);
    write_reg(ugns_pkg::REG_INV_SP, inv);
    write_reg(ugns_pkg::REG_OFFSET, off);
  endtask

  task automatic send_item(ugns_pkg::kind_e k, int unsigned idx = 0, shortint x = 0,
                           shortint y = 0, shortint z = 0);
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      repeat ($urandom_range(0, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 30);
    end
    s_valid <= 1'b1;
    s_data  <= {6'b0, z, y, x, idx[9:0]};
    s_user  <= k;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    burst_left--;
    case (k)
      ugns_pkg::KIND_LOAD: begin
        pos_tab[idx][0] = x;
        pos_tab[idx][1] = y;
        pos_tab[idx][2] = z;
      end
      ugns_pkg::KIND_BUILD: grid_build();
      ugns_pkg::KIND_QUERY: query_open(idx);
      default: nbr_q.push_back(next_neighbor());
    endcase
  endtask

  // block idle: all results back and sequencer ready again
  task automatic wait_drained();
    s_valid <= 1'b0;
    while (nbr_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic shortint rand_coord(int unsigned n);
    longint smax, p;
    if ($urandom_range(0, 4) == 0 || r_inv == 0) return shortint'($urandom);
    smax = (longint'(n + 1) << 20) / r_inv;
    if (smax > 100000) smax = 100000;
    p = longint'($urandom_range(0, int'(smax))) - longint'($urandom_range(0, 256))
        - longint'(r_off);
    if (p < -32768) p = -32768;
    if (p > 32767) p = 32767;
    return shortint'(p);
  endfunction

  task automatic load_random(int unsigned idx);
    send_item(ugns_pkg::KIND_LOAD, idx, rand_coord(axis_n(r_cx)),
              rand_coord(axis_n(r_cy)), rand_coord(axis_n(r_cz)));
  endtask

  task automatic query_and_walk(int unsigned q, int unsigned steps);
    send_item(ugns_pkg::KIND_QUERY, q);
    repeat (steps) send_item(ugns_pkg::KIND_NEXT);
  endtask

  task automatic test_directed_cases();
    send_item(ugns_pkg::KIND_NEXT);
    wait_drained();
    write_reg(ugns_pkg::REG_PCOUNT, 3);
    send_item(ugns_pkg::KIND_LOAD, 0, -16'sd32768, 16'sd32767, 16'sd0);
    send_item(ugns_pkg::KIND_LOAD, 1, 16'sd0, 16'sd0, 16'sd0);
    send_item(ugns_pkg::KIND_LOAD, 2, 16'sd256, 16'sd256, 16'sd256);
    send_item(ugns_pkg::KIND_LOAD, 1023, -16'sd1, -16'sd1, -16'sd1);
    send_item(ugns_pkg::KIND_LOAD, 682, 16'sd100, 16'sd50, 16'sd25);
    // query on an unbuilt grid
    query_and_walk(1, 1);
    send_item(ugns_pkg::KIND_BUILD);
    query_and_walk(1, 3);
    // far negative coordinate puts the window off the grid
    query_and_walk(0, 1);
    query_and_walk(1023, 3);
    // build closes an open window
    query_and_walk(2, 1);
    send_item(ugns_pkg::KIND_BUILD);
    send_item(ugns_pkg::KIND_NEXT);
    query_and_walk(682, 2);
    wait_drained();
  endtask

  task automatic test_random_grids();
    int unsigned nl, r;
    for (int ph = 0; ph < 4; ph++) begin
      nl = $urandom_range(1, 40);
      case (ph)
        0: set_grid(nl, 31, 0, 1, 65535, 65535);
        1: set_grid(nl, 16, 1, 0, 0, 0);
        2: set_grid(0, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 65535),
                    $urandom_range(0, 65535));
        default: set_grid(nl, $urandom_range(1, 6), $urandom_range(1, 6),
                          $urandom_range(1, 6), $urandom_range(1024, 16384),
                          $urandom_range(0, 2048));
      endcase
      for (int unsigned i = 0; i < nl; i++) load_random(i);
      send_item(ugns_pkg::KIND_BUILD);
      for (int k = 0; k < 30; k++) begin
        if (k == 15) begin
          // registers move under a built grid: stale starts
          wait_drained();
          write_reg(ugns_pkg::REG_INV_SP, $urandom_range(0, 65535));
          write_reg(ugns_pkg::REG_OFFSET, $urandom_range(0, 65535));
        end
        r = $urandom_range(0, 19);
        if (r < 2) load_random($urandom_range(0, NPART - 1));
        else if (r == 2) send_item(ugns_pkg::KIND_BUILD);
        else if (r < 8) query_and_walk($urandom_range(0, nl - 1), $urandom_range(1, 8));
        else send_item(ugns_pkg::KIND_NEXT);
      end
      wait_drained();
    end
  endtask

  task automatic test_full_grid();
    set_grid(FULL_N, 16, 16, 31, 4096, 1024);
    for (int unsigned i = 0; i < FULL_N; i++)
      send_item(ugns_pkg::KIND_LOAD, i, shortint'($urandom_range(0, 4095)) - 16'sd1024,
                shortint'($urandom_range(0, 4095)) - 16'sd1024,
                shortint'($urandom_range(0, 4095)) - 16'sd1024);
    send_item(ugns_pkg::KIND_BUILD);
    for (int q = 0; q < 4; q++)
      query_and_walk($urandom_range(0, FULL_N - 1), 14);
    wait_drained();
  endtask

  // receiver stall pattern
  int stall_mode = 0, stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    case (stall_mode)
      0: m_ready <= 1'b1;
      1: m_ready <= ($urandom_range(0, 3) != 0);
      default: m_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    nbr_t want;
    if (rst_ni && m_axis_tvalid && m_ready) begin
      if (nbr_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result id=%0d found=%0b",
                                   m_axis_tdata[9:0], m_axis_tuser[0]);
      end else begin
        want = nbr_q.pop_front();
        if (m_axis_tdata[9:0] !== want.id || m_axis_tuser[0] !== want.found) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected id=%0d found=%0b, got id=%0d found=%0b",
                     want.id, want.found, m_axis_tdata[9:0], m_axis_tuser[0]);
        end
      end
    end
  end

  initial begin
    #200ms;
    $display("status: fail");
    $finish;
  end

  initial begin
    r_pcount = 1024;
    r_cx = 16;
    r_cy = 16;
    r_cz = 16;
    r_inv = 4096;
    r_off = 1024;
    q_part = 0;
    walk_pos = 0;
    walk_end = 0;
    walk_on = 1'b0;
    foreach (start_tab[i]) start_tab[i] = 0;
    foreach (id_tab[i]) id_tab[i] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_grids();
    test_full_grid();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && nbr_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/ugns_pkg.sv
hdl/ugns_dp.sv
hdl/ugns_ctrl.sv
hdl/uniform_grid_neighbor_search.sv
verif/tb_top.sv
